// ----- sv/gwm_pkg.sv -----
// Shared types, constants and helper functions of the glob wildcard matcher.
`timescale 1ns / 1ps
`default_nettype none
package gwm_pkg;

	localparam int MAX_PATTERN = 64;
	localparam int PW = $clog2(MAX_PATTERN);
	localparam int LW = $clog2(MAX_PATTERN + 1);

	localparam logic [7:0] META_ANY   = 8'hBF;
	localparam logic [7:0] META_STAR  = 8'hAA;
	localparam logic [7:0] META_CLASS = 8'hDB;
	localparam logic [7:0] ESC_BYTE   = 8'h5C;
	localparam logic [7:0] CLASS_NOT  = 8'h5E;
	localparam logic [7:0] CLASS_END  = 8'h5D;
	localparam logic [7:0] CLASS_DASH = 8'h2D;

	typedef enum logic [1:0] {
		FN_PAT  = 2'd0,
		FN_TEXT = 2'd1,
		FN_END  = 2'd2,
		FN_NONE = 2'd3
	} func_t;

	// Pattern-derived vectors, stable while text items are in flight.
	typedef struct packed {
		logic [MAX_PATTERN-1:0] kill;
		logic [MAX_PATTERN-1:0] fire;
		logic [MAX_PATTERN-1:0] star;
		logic [LW-1:0]          len;
		logic                   last_star;
		logic                   ovf;
	} pat_info_t;

	typedef struct packed {
		logic                   is_end;
		logic [MAX_PATTERN-1:0] ehit;
	} q_item_t;

	function automatic logic [7:0] fold(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= 8'd65 && b <= 8'd90) r = b | 8'h20;
		return r;
	endfunction

	// Segmented OR scan: each position gets the OR of v from the nearest
	// segment start at or below it. Log-depth, one level per doubling.
	function automatic logic [MAX_PATTERN-1:0] seg_or(input logic [MAX_PATTERN-1:0] v,
		input logic [MAX_PATTERN-1:0] k);
		logic [MAX_PATTERN-1:0] val;
		logic [MAX_PATTERN-1:0] flg;
		logic [MAX_PATTERN-1:0] nv;
		logic [MAX_PATTERN-1:0] nf;
		val = v;
		flg = k;
		for (int s = 1; s < MAX_PATTERN; s = s * 2) begin
			nv = val;
			nf = flg;
			for (int p = s; p < MAX_PATTERN; p++) begin
				if (!flg[p]) nv[p] = val[p] | val[p-s];
				nf[p] = flg[p] | flg[p-s];
			end
			val = nv;
			flg = nf;
		end
		return val;
	endfunction

endpackage
`default_nettype wire

// ----- sv/gwm_fifo.sv -----
// Two-entry queue between the front and the back of the matcher.
`timescale 1ns / 1ps
`default_nettype none
module gwm_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire gwm_pkg::q_item_t push_item,
	input  wire logic             pop,
	output gwm_pkg::q_item_t      pop_item,
	output logic                  full,
	output logic                  empty,
	output logic [1:0]            count
);
	import gwm_pkg::*;

	q_item_t    mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign count    = cnt_q;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule
`default_nettype wire

// ----- sv/gwm_front.sv -----
// Front end: input handshake, pattern loader and per-element hit evaluation.
`timescale 1ns / 1ps
`default_nettype none
module gwm_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	input  wire logic [7:0]    s_axis_tdata,
	input  wire logic [2:0]    s_axis_tuser,
	output logic               q_push,
	output gwm_pkg::q_item_t   q_item,
	input  wire logic          q_full,
	input  wire logic          q_empty,
	output gwm_pkg::pat_info_t pinfo,
	output logic               scan_restart,
	output logic               busy
);
	import gwm_pkg::*;

	typedef enum logic [4:0] {
		LD_NORM   = 5'b00001,
		LD_ESC    = 5'b00010,
		LD_CFIRST = 5'b00100,
		LD_CBODY  = 5'b01000,
		LD_CDASH  = 5'b10000
	} ld_state_t;

	func_t      func;
	logic       restart;
	logic [7:0] byte_in;
	logic       acc;

	logic [7:0]             pat_q [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] start_q, star_q, any_q, inv_q, cmp_q, rng_q;
	logic [LW-1:0]          len_q;
	logic                   ovf_q;
	ld_state_t              ld_q;
	logic                   ls_q;
	logic                   memv_q;

	logic                   s1_valid_q;
	logic                   s1_end_s1;
	logic [7:0]             s1_byte_s1;
	logic                   s1_adv;

	logic [LW-1:0] eff_len;
	logic          eff_ovf;
	ld_state_t     eff_state;
	logic          eff_ls;
	logic          eff_memv;
	logic          pat_acc;
	logic          do_wr;
	logic [PW-1:0] widx;
	logic [PW-1:0] pidx;
	logic          n_start, n_star, n_any, n_cmp, n_rng, clr_prev, set_inv;
	ld_state_t     nxt_state;
	logic          nxt_ls;
	logic          nxt_memv;

	assign func    = func_t'(s_axis_tuser[1:0]);
	assign restart = s_axis_tuser[2];
	assign byte_in = s_axis_tdata;

	assign busy   = s1_valid_q | ~q_empty;
	assign s1_adv = s1_valid_q & ~q_full;

	// A pattern byte waits until every earlier text item has left the queue.
	always_comb begin
		unique case (func)
			FN_PAT:         s_axis_tready = ~busy;
			FN_TEXT, FN_END: s_axis_tready = ~s1_valid_q | s1_adv;
			default:        s_axis_tready = 1'b1;
		endcase
	end

	assign acc          = s_axis_tvalid & s_axis_tready;
	assign pat_acc      = acc & (func == FN_PAT);
	assign scan_restart = pat_acc;

	// Pattern loader: incremental parse of the element structure.
	always_comb begin
		eff_len   = restart ? '0 : len_q;
		eff_ovf   = restart ? 1'b0 : ovf_q;
		eff_state = restart ? LD_NORM : ld_q;
		eff_ls    = restart ? 1'b0 : ls_q;
		eff_memv  = restart ? 1'b0 : memv_q;
		do_wr     = pat_acc & (eff_len < LW'(MAX_PATTERN));
		widx      = eff_len[PW-1:0];
		pidx      = widx - 1'b1;
		n_start   = 1'b0;
		n_star    = 1'b0;
		n_any     = 1'b0;
		n_cmp     = 1'b0;
		n_rng     = 1'b0;
		clr_prev  = 1'b0;
		set_inv   = 1'b0;
		nxt_state = eff_state;
		nxt_ls    = eff_ls;
		nxt_memv  = eff_memv;
		priority if (eff_state == LD_NORM) begin
			n_start = 1'b1;
			nxt_ls  = 1'b0;
			priority if (byte_in == META_STAR) begin
				// A run of stars behaves as one star, so it forms one element.
				nxt_ls = 1'b1;
				if (eff_ls) n_start = 1'b0;
				else n_star = 1'b1;
			end else if (byte_in == META_ANY) begin
				n_any = 1'b1;
			end else if (byte_in == ESC_BYTE) begin
				n_cmp     = 1'b1;
				nxt_state = LD_ESC;
			end else if (byte_in == META_CLASS) begin
				nxt_state = LD_CFIRST;
				nxt_memv  = 1'b0;
			end else begin
				n_cmp = 1'b1;
			end
		end else if (eff_state == LD_ESC) begin
			clr_prev  = 1'b1;
			n_cmp     = 1'b1;
			nxt_state = LD_NORM;
		end else if (eff_state == LD_CDASH) begin
			n_rng     = eff_memv;
			nxt_memv  = 1'b1;
			nxt_state = LD_CBODY;
		end else if (eff_state == LD_CFIRST && byte_in == CLASS_NOT) begin
			set_inv   = 1'b1;
			nxt_state = LD_CBODY;
		end else begin
			priority if (byte_in == CLASS_END) begin
				nxt_state = LD_NORM;
			end else if (byte_in == CLASS_DASH) begin
				nxt_state = LD_CDASH;
			end else begin
				n_cmp     = 1'b1;
				nxt_memv  = 1'b1;
				nxt_state = LD_CBODY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			ovf_q  <= 1'b0;
			ld_q   <= LD_NORM;
			ls_q   <= 1'b0;
			memv_q <= 1'b0;
		end else if (pat_acc) begin
			if (do_wr) begin
				len_q  <= eff_len + 1'b1;
				ovf_q  <= eff_ovf;
				ld_q   <= nxt_state;
				ls_q   <= nxt_ls;
				memv_q <= nxt_memv;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			pat_q[widx]   <= byte_in;
			start_q[widx] <= n_start;
			star_q[widx]  <= n_star;
			any_q[widx]   <= n_any;
			inv_q[widx]   <= 1'b0;
			cmp_q[widx]   <= n_cmp;
			rng_q[widx]   <= n_rng;
			if (clr_prev) cmp_q[pidx] <= 1'b0;
			if (set_inv) inv_q[pidx] <= 1'b1;
		end
	end

	// Element boundaries and the vectors the back end steps with.
	logic [MAX_PATTERN-1:0] lenmask, st, sstar, starseg, endm, kill;
	logic [LW-1:0]          lm1;

	always_comb begin
		for (int p = 0; p < MAX_PATTERN; p++) begin
			lenmask[p] = (p < int'(len_q));
		end
		st      = start_q & lenmask;
		sstar   = star_q & lenmask;
		starseg = seg_or(sstar, st);
		for (int p = 0; p < MAX_PATTERN - 1; p++) begin
			endm[p] = ((p + 1) < int'(len_q)) ? st[p+1] : ((p + 1) == int'(len_q));
		end
		endm[MAX_PATTERN-1] = (int'(len_q) == MAX_PATTERN);
		kill[0] = 1'b1;
		for (int p = 1; p < MAX_PATTERN; p++) begin
			// The element after a star joins its segment, which closes the star.
			kill[p] = st[p] & ~starseg[p-1];
		end
		lm1 = len_q - 1'b1;
	end

	assign pinfo.kill      = kill;
	assign pinfo.fire      = endm & lenmask & ~starseg;
	assign pinfo.star      = sstar;
	assign pinfo.len       = len_q;
	assign pinfo.last_star = (len_q != '0) & starseg[lm1[PW-1:0]];
	assign pinfo.ovf       = ovf_q;

	// Stage 1: hit of every element against the folded text byte.
	logic [7:0]             ft;
	logic [MAX_PATTERN-1:0] mh;
	logic [7:0]             fp;
	logic [7:0]             lo;

	always_comb begin
		ft = fold(s1_byte_s1);
		for (int p = 0; p < MAX_PATTERN; p++) begin
			fp = fold(pat_q[p]);
			lo = (p >= 2) ? fold(pat_q[(p >= 2) ? p - 2 : 0]) : 8'd0;
			mh[p] = (cmp_q[p] & (ft == fp)) |
				(rng_q[p] & ($signed(ft) <= $signed(fp)) & ($signed(ft) >= $signed(lo)));
		end
	end

	assign q_push        = s1_adv;
	assign q_item.is_end = s1_end_s1;
	assign q_item.ehit   = seg_or(mh | any_q, st) ^ seg_or(inv_q, st);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc && (func == FN_TEXT || func == FN_END)) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (func == FN_TEXT || func == FN_END)) begin
			s1_end_s1  <= (func == FN_END);
			s1_byte_s1 <= byte_in;
		end
	end

endmodule
`default_nettype wire

// ----- sv/gwm_back.sv -----
// Back end: active-position vector, star closure and the result register.
`timescale 1ns / 1ps
`default_nettype none
module gwm_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire gwm_pkg::pat_info_t pinfo,
	input  wire logic               scan_restart,
	input  wire gwm_pkg::q_item_t   q_item,
	input  wire logic               q_empty,
	output logic                    q_pop,
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	output logic [7:0]              m_axis_tdata
);
	import gwm_pkg::*;

	logic [MAX_PATTERN:0]   act_q;
	logic [MAX_PATTERN:0]   nxt;
	logic [MAX_PATTERN-1:0] fwd;
	logic [LW-1:0]          lm1;
	logic                   match;
	logic                   out_valid_q;
	logic                   matched_q;
	logic                   ovf_out_q;

	always_comb begin
		fwd = seg_or(act_q[MAX_PATTERN-1:0], pinfo.kill);
		nxt[0] = act_q[0] & pinfo.star[0];
		for (int p = 1; p < MAX_PATTERN; p++) begin
			nxt[p] = (fwd[p-1] & q_item.ehit[p-1] & pinfo.fire[p-1]) |
				(act_q[p] & pinfo.star[p]);
		end
		nxt[MAX_PATTERN] = fwd[MAX_PATTERN-1] & q_item.ehit[MAX_PATTERN-1] &
			pinfo.fire[MAX_PATTERN-1];
		lm1   = pinfo.len - 1'b1;
		match = act_q[pinfo.len] | (pinfo.last_star & fwd[lm1[PW-1:0]]);
	end

	assign q_pop = ~q_empty & (~q_item.is_end | ~out_valid_q | m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= (MAX_PATTERN + 1)'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (scan_restart || (q_pop && q_item.is_end)) act_q <= (MAX_PATTERN + 1)'(1);
			else if (q_pop) act_q <= nxt;
			if (q_pop && q_item.is_end) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_item.is_end) begin
			matched_q <= match;
			ovf_out_q <= pinfo.ovf;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, ovf_out_q, matched_q};

endmodule
`default_nettype wire

// ----- sv/glob_wildcard_matcher.sv -----
// Top level of the glob wildcard matcher: front end, queue and back end.
//
//  Channel  Dir  Payload                                    Items
//  s_axis   in   tdata: data_byte; tuser: func, restart     pattern, text, end
//  m_axis   out  tdata: matched, pattern_overflow           one per end item
//
// Text and end items are taken one per cycle while the queue has room; a text byte
// passes the hit stage register and the queue before it updates the active vector.
// A pattern byte is taken only once the stage and the queue have drained, so it
// waits for the last text item to pass, and longer while a result waits.
// Reset leaves an empty pattern with only the start position active.
// The result register lets the front keep accepting while a result waits.
`timescale 1ns / 1ps
`default_nettype none
module glob_wildcard_matcher (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  wire logic [2:0] s_axis_tuser,   // [1:0] func, [2] restart
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata    // [0] matched, [1] pattern_overflow, rest zero
);
	import gwm_pkg::*;

	q_item_t    push_item;
	q_item_t    pop_item;
	pat_info_t  pinfo;
	logic       q_push;
	logic       q_pop;
	logic       q_full;
	logic       q_empty;
	logic [1:0] q_count;
	logic       scan_restart;
	logic       busy;

	gwm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_push        (q_push),
		.q_item        (push_item),
		.q_full        (q_full),
		.q_empty       (q_empty),
		.pinfo         (pinfo),
		.scan_restart  (scan_restart),
		.busy          (busy)
	);

	gwm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.full      (q_full),
		.empty     (q_empty),
		.count     (q_count)
	);

	gwm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pinfo         (pinfo),
		.scan_restart  (scan_restart),
		.q_item        (pop_item),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

`ifndef SYNTHESIS
	a_pat_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser[1:0] == FN_PAT) |-> !busy)
		else $error("pattern byte taken while text items in flight");

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_count != 2'd2))
		else $error("queue pushed while full");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pinfo.len <= LW'(MAX_PATTERN))
		else $error("pattern length beyond capacity");

	a_restart_idle: assert property (@(posedge clk) disable iff (!arst_n)
		scan_restart |-> !q_pop)
		else $error("scan restart while back end busy");
`endif

endmodule
`default_nettype wire
